[src/lfu_pkg.sv]
`default_nettype none

package lfu_pkg;

	// stamp width is fixed by the time_now field
	localparam int STAMP_BITS = 32;

	// default geometry
	localparam int WAYS_DEF       = 8;
	localparam int SETS_DEF       = 64;
	localparam int COUNT_BITS_DEF = 16;

	// field widths of one input transaction
	localparam int ACTION_BITS = 2;
	localparam int SET_BITS    = 6;
	localparam int WAY_BITS    = 3;

	typedef enum logic [ACTION_BITS-1:0] {
		ACT_INVALIDATE = 2'd0,
		ACT_TOUCH      = 2'd1,
		ACT_INSTALL    = 2'd2,
		ACT_VICTIM     = 2'd3
	} action_t;

endpackage

`default_nettype wire

[src/lfu_mem.sv]
`default_nettype none

module lfu_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 384
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[src/lfu_pick.sv]
`default_nettype none

module lfu_pick #(
	parameter int WAYS       = lfu_pkg::WAYS_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
	parameter int LEVELS     = $clog2(WAYS),
	parameter int WAY_AW     = (WAYS > 1) ? $clog2(WAYS) : 1
) (
	input  wire logic                                               clk,
	input  wire logic                                               arst_n,
	input  wire logic                                               start,
	input  wire logic [WAYS*(COUNT_BITS+lfu_pkg::STAMP_BITS)-1:0] row,
	output logic                                                    busy,
	output logic      [WAY_AW-1:0]                                  best_way
);

	import lfu_pkg::*;

	localparam int EW    = COUNT_BITS + STAMP_BITS;
	localparam int NPOW  = 1 << LEVELS;
	localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	typedef struct packed {
		logic                  valid;
		logic [COUNT_BITS-1:0] cnt;
		logic [STAMP_BITS-1:0] stamp;
		logic [WAY_AW-1:0]     idx;
	} cand_t;

	cand_t            cand_q [NPOW];
	logic [LVL_W-1:0] lvl_q;
	logic             busy_q;
	logic [NPOW*EW-1:0] row_ext;

	// left entry keeps ties, so the lower way wins among equals
	function automatic cand_t better(input cand_t a, input cand_t b);
		logic b_wins;
		b_wins = b.valid && (!a.valid || (b.cnt < a.cnt) ||
			((b.cnt == a.cnt) && (b.stamp < a.stamp)));
		return b_wins ? b : a;
	endfunction

	assign row_ext = (NPOW*EW)'(row);

	// one tree level per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < NPOW; i++) begin
				cand_q[i].valid <= (i < WAYS);
				cand_q[i].cnt   <= row_ext[i*EW +: COUNT_BITS];
				cand_q[i].stamp <= row_ext[i*EW+COUNT_BITS +: STAMP_BITS];
				cand_q[i].idx   <= WAY_AW'(i);
			end
		end else if (busy_q) begin
			for (int i = 0; i < NPOW/2; i++) begin
				cand_q[i] <= better(cand_q[2*i], cand_q[2*i+1]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			lvl_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			lvl_q  <= '0;
		end else if (busy_q) begin
			lvl_q <= lvl_q + 1'b1;
			if (lvl_q == LVL_W'(LEVELS-1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy     = busy_q;
	assign best_way = cand_q[0].idx;

endmodule

`default_nettype wire

[src/lfu_replacement_with_age_tiebreak.sv]
`default_nettype none

// channel   dir  transaction fields (tdata / tuser, lowest bit first)
// s_axis    in   tdata: set_index[5:0] way[8:6] time_now[40:9], zero pad to 48
//                tuser: action[1:0]
// m_axis    out  tdata: victim_way[2:0], zero pad to 8
//                tuser: is_victim_answer
//
// an update (invalidate, touch, install) has an accept + row read step,
// then modify and write back of the set row in the row memory
// a victim query on a set in range has accept + row read, tree load,
// one comparator tree level a cycle, then the answer step
// after reset a clearing pass writes zero to every set row,
// with s_axis_tready low until it is done
// one result is held in the output register; the block stalls in its
// write-back or answer step only while that register is full and not taken

module lfu_replacement_with_age_tiebreak #(
	parameter int WAYS       = lfu_pkg::WAYS_DEF,
	parameter int SETS       = lfu_pkg::SETS_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // set_index, way, time_now, pad
	input  wire logic [1:0]  s_axis_tuser,  // action
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [7:0]  m_axis_tdata,  // victim_way, pad
	output logic             m_axis_tuser   // is_victim_answer
);

	import lfu_pkg::*;

	localparam int EW     = COUNT_BITS + STAMP_BITS;   // one way: count then stamp
	localparam int RW     = WAYS * EW;                 // one set row
	localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_AW = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_PICK
	} state_t;

	state_t state_q;

	// captured transaction
	action_t               action_q;
	logic [SET_BITS-1:0]   set_q;
	logic [WAY_BITS-1:0]   way_q;
	logic [STAMP_BITS-1:0] now_q;

	logic [SET_AW-1:0] clr_q;

	// output register
	logic                out_valid_q;
	logic [WAY_BITS-1:0] out_way_q;
	logic                out_ans_q;

	logic              accept;
	logic              slot_free;
	logic              out_load;
	logic              set_ok;
	logic              way_ok;
	logic              is_update;
	logic [WAY_AW-1:0] way_idx;

	logic              mem_we;
	logic [SET_AW-1:0] mem_waddr;
	logic [RW-1:0]     mem_wdata;
	logic [RW-1:0]     rd_row;
	logic [RW-1:0]     new_row;

	logic [COUNT_BITS-1:0] old_cnt;
	logic [COUNT_BITS-1:0] upd_cnt;
	logic [STAMP_BITS-1:0] old_stamp;
	logic [STAMP_BITS-1:0] upd_stamp;

	logic              pick_start;
	logic              pick_busy;
	logic [WAY_AW-1:0] pick_way;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign slot_free     = !out_valid_q || m_axis_tready;

	// a new result enters the output register this cycle
	assign out_load = slot_free && (((state_q == ST_READ) && !pick_start) ||
		((state_q == ST_PICK) && !pick_busy));

	// out-of-range set or way: no state change
	assign set_ok    = 32'(set_q) < 32'(SETS);
	assign way_ok    = 32'(way_q) < 32'(WAYS);
	assign is_update = (action_q != ACT_VICTIM);
	assign way_idx   = WAY_AW'(way_q);

	// read-modify-write of the addressed way
	always_comb begin
		old_cnt   = rd_row[way_idx*EW +: COUNT_BITS];
		old_stamp = rd_row[way_idx*EW+COUNT_BITS +: STAMP_BITS];
		upd_cnt   = old_cnt;
		upd_stamp = old_stamp;
		unique case (action_q)
			ACT_INVALIDATE: begin
				upd_cnt   = '0;
				upd_stamp = now_q;
			end
			ACT_TOUCH: begin
				// saturating increment
				if (old_cnt != '1) begin
					upd_cnt = old_cnt + 1'b1;
				end
			end
			ACT_INSTALL: begin
				upd_cnt   = COUNT_BITS'(1);
				upd_stamp = now_q;
			end
			default: begin
			end
		endcase
		new_row = rd_row;
		new_row[way_idx*EW +: EW] = {upd_stamp, upd_cnt};
	end

	// the clearing pass and the write-back share the single write port
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = (state_q == ST_READ) && is_update && slot_free && set_ok && way_ok;
			mem_waddr = SET_AW'(set_q);
			mem_wdata = new_row;
		end
	end

	assign pick_start = (state_q == ST_READ) && !is_update && set_ok;

	lfu_mem #(
		.DEPTH (SETS),
		.AW    (SET_AW),
		.DW    (RW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (SET_AW'(s_axis_tdata[5:0])),
		.rdata (rd_row)
	);

	lfu_pick #(
		.WAYS       (WAYS),
		.COUNT_BITS (COUNT_BITS)
	) u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pick_start),
		.row      (rd_row),
		.busy     (pick_busy),
		.best_way (pick_way)
	);

	// transaction capture, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action_t'(s_axis_tuser);
			set_q    <= s_axis_tdata[5:0];
			way_q    <= s_axis_tdata[8:6];
			now_q    <= s_axis_tdata[40:9];
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			out_way_q   <= '0;
			out_ans_q   <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_AW'(SETS-1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (pick_start) begin
						state_q <= ST_PICK;
					end else if (slot_free) begin
						// update done, or query on a missing set answers way 0
						out_valid_q <= 1'b1;
						out_way_q   <= '0;
						out_ans_q   <= !is_update;
						state_q     <= ST_IDLE;
					end
				end
				ST_PICK: begin
					if (!pick_busy && slot_free) begin
						out_valid_q <= 1'b1;
						out_way_q   <= WAY_BITS'(pick_way);
						out_ans_q   <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_way_q};
	assign m_axis_tuser  = out_ans_q;

endmodule

`default_nettype wire
